// ===== design/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants of the program map section parser
// Parser phases, result record layout, header offsets and register map.
// ----------------------------------------------------------------------------
package pmt_pkg;

  // header and entry geometry
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned ENTRY_BYTES  = 5;
  localparam int unsigned POS_W        = 13;
  localparam int unsigned LEN_W        = 12;
  localparam int unsigned PID_W        = 13;
  localparam int unsigned IDX_W        = $clog2(ENTRY_BYTES);

  // byte offsets within the section header, table id at offset 0
  localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_PROG_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PROG_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_INFO_HI = POS_W'(10);
  localparam logic [POS_W-1:0] POS_INFO_LO = POS_W'(HEADER_BYTES - 1);

  // smallest section length with room for header and crc
  localparam logic [LEN_W-1:0] MIN_SECTION_LEN = LEN_W'(HEADER_BYTES + 1);

  // byte offsets within an elementary stream entry
  localparam logic [IDX_W-1:0] ENT_TYPE    = IDX_W'(0);
  localparam logic [IDX_W-1:0] ENT_PID_HI  = IDX_W'(1);
  localparam logic [IDX_W-1:0] ENT_PID_LO  = IDX_W'(2);
  localparam logic [IDX_W-1:0] ENT_INFO_HI = IDX_W'(3);
  localparam logic [IDX_W-1:0] ENT_LAST    = IDX_W'(ENTRY_BYTES - 1);

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // result kinds
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register map
  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_AUDIO   = 1'b0;
  localparam logic        REG_VIDEO   = 1'b1;
  localparam logic [7:0]  AUDIO_RESET = 8'd3;
  localparam logic [7:0]  VIDEO_RESET = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_ENTRY,
    PH_TRAILER
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic [7:0]       tbl_id;
    logic [15:0]      prog_num;
    logic [7:0]       strm_type;
    logic [PID_W-1:0] es_pid;
    logic [LEN_W-1:0] es_desc_len;
    logic [7:0]       stream_count;
    logic [PID_W-1:0] audio_pid;
    logic             audio_found;
    logic [PID_W-1:0] video_pid;
    logic             video_found;
    logic             malformed;
  } res_t;

endpackage

// ===== design/pmt_in_if.sv =====
// ----------------------------------------------------------------------------
// pmt_in_if: section byte channel
// Valid/ready channel carrying one section byte and its start marker.
// ----------------------------------------------------------------------------
interface pmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_start;

  modport source (output valid, data_byte, section_start, input ready);
  modport sink   (input valid, data_byte, section_start, output ready);
endinterface

// ===== design/pmt_out_if.sv =====
// ----------------------------------------------------------------------------
// pmt_out_if: parser result channel
// Valid/ready channel carrying entry records and section summaries.
// ----------------------------------------------------------------------------
interface pmt_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tbl_id;
  logic [15:0] prog_num;
  logic [7:0]  strm_type;
  logic [12:0] es_pid;
  logic [11:0] es_desc_len;
  logic [7:0]  stream_count;
  logic [12:0] audio_pid;
  logic        audio_found;
  logic [12:0] video_pid;
  logic        video_found;
  logic        malformed;

  modport source (
    output valid, kind, tbl_id, prog_num, strm_type, es_pid,
           es_desc_len, stream_count, audio_pid, audio_found, video_pid,
           video_found, malformed,
    input  ready
  );
  modport sink (
    input  valid, kind, tbl_id, prog_num, strm_type, es_pid,
           es_desc_len, stream_count, audio_pid, audio_found, video_pid,
           video_found, malformed,
    output ready
  );
endinterface

// ===== design/pmt_core.sv =====
// ----------------------------------------------------------------------------
// pmt_core: per-byte section parser
// Walks header, descriptor loops and entries; at most one result per accepted byte.
// ----------------------------------------------------------------------------
module pmt_core
  import pmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] data_byte_i,
  input  logic       section_start_i,
  input  logic [7:0] audio_type_i,
  input  logic [7:0] video_type_i,
  output logic       res_valid_o,
  output res_t       res_o,
  output phase_e     phase_o
);

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] skip_q, skip_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       etype_q, etype_d;
  logic [PID_W-1:0] epid_q, epid_d;
  logic [LEN_W-1:0] einfo_q, einfo_d;
  logic [7:0]       tid_q, tid_d;
  logic [15:0]      prog_q, prog_d;
  logic [7:0]       count_q, count_d;
  logic             afound_q, afound_d;
  logic [PID_W-1:0] apid_q, apid_d;
  logic             vfound_q, vfound_d;
  logic [PID_W-1:0] vpid_q, vpid_d;
  logic             err_q, err_d;
  logic             res_kind;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] crc_pos;
  logic [POS_W-1:0] end_pos;
  logic             crc_hit;
  logic             end_hit;
  logic             len_short;
  logic [LEN_W-1:0] hdr_skip;
  logic [LEN_W-1:0] skip_dec;
  logic [LEN_W-1:0] info_full;
  logic             entry_done;

  assign pos_inc    = pos_q + POS_W'(1);
  assign crc_pos    = {1'b0, len_q} - POS_W'(1);
  assign end_pos    = {1'b0, len_q} + POS_W'(2);
  assign crc_hit    = pos_inc >= crc_pos;
  assign end_hit    = pos_inc >= end_pos;
  assign len_short  = len_q < MIN_SECTION_LEN;
  assign hdr_skip   = {skip_q[LEN_W-1:8], data_byte_i};
  assign skip_dec   = skip_q - LEN_W'(1);
  assign info_full  = {einfo_q[LEN_W-1:8], data_byte_i};
  assign entry_done = idx_q == ENT_LAST;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_fire_i) begin
      if (section_start_i) begin
        phase_d = PH_HEADER;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (pos_inc == POS_INFO_LO) begin
              if (len_short) phase_d = PH_IDLE;
              else if (hdr_skip != '0) phase_d = PH_SKIP;
              else phase_d = PH_ENTRY;
            end
          end
          PH_SKIP: begin
            if (crc_hit) phase_d = end_hit ? PH_IDLE : PH_TRAILER;
            else if (skip_dec == '0) phase_d = PH_ENTRY;
          end
          PH_ENTRY: begin
            if (crc_hit) phase_d = end_hit ? PH_IDLE : PH_TRAILER;
            else if (entry_done && info_full != '0) phase_d = PH_SKIP;
          end
          PH_TRAILER: begin
            if (crc_hit && end_hit) phase_d = PH_IDLE;
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // field capture and result strobe
  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    skip_d      = skip_q;
    idx_d       = idx_q;
    etype_d     = etype_q;
    epid_d      = epid_q;
    einfo_d     = einfo_q;
    tid_d       = tid_q;
    prog_d      = prog_q;
    count_d     = count_q;
    afound_d    = afound_q;
    apid_d      = apid_q;
    vfound_d    = vfound_q;
    vpid_d      = vpid_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    res_kind    = KIND_ENTRY;

    if (in_fire_i && section_start_i) begin
      pos_d    = '0;
      len_d    = '0;
      skip_d   = '0;
      idx_d    = '0;
      etype_d  = '0;
      epid_d   = '0;
      einfo_d  = '0;
      tid_d    = data_byte_i;
      prog_d   = '0;
      count_d  = '0;
      afound_d = 1'b0;
      apid_d   = '0;
      vfound_d = 1'b0;
      vpid_d   = '0;
      err_d    = 1'b0;
    end else if (in_fire_i && phase_q != PH_IDLE) begin
      pos_d = pos_inc;
      if (phase_q == PH_HEADER) begin
        unique case (pos_inc)
          POS_LEN_HI:  len_d  = {data_byte_i[3:0], 8'h00};
          POS_LEN_LO:  len_d  = {len_q[LEN_W-1:8], data_byte_i};
          POS_PROG_HI: prog_d = {data_byte_i, 8'h00};
          POS_PROG_LO: prog_d = {prog_q[15:8], data_byte_i};
          POS_INFO_HI: skip_d = {data_byte_i[3:0], 8'h00};
          POS_INFO_LO: begin
            skip_d = hdr_skip;
            idx_d  = '0;
            if (len_short) begin
              err_d       = 1'b1;
              res_valid_o = 1'b1;
              res_kind    = KIND_SUMMARY;
            end
          end
          default: ;
        endcase
      end else if (crc_hit) begin
        // descriptor loop or entry cut short by the crc
        if (phase_q == PH_SKIP || (phase_q == PH_ENTRY && idx_q != '0)) begin
          err_d = 1'b1;
        end
        if (end_hit) begin
          res_valid_o = 1'b1;
          res_kind    = KIND_SUMMARY;
        end
      end else if (phase_q == PH_SKIP) begin
        skip_d = skip_dec;
        if (skip_dec == '0) idx_d = '0;
      end else if (phase_q == PH_ENTRY) begin
        unique case (idx_q)
          ENT_TYPE:    etype_d = data_byte_i;
          ENT_PID_HI:  epid_d  = {data_byte_i[4:0], 8'h00};
          ENT_PID_LO:  epid_d  = {epid_q[PID_W-1:8], data_byte_i};
          ENT_INFO_HI: einfo_d = {data_byte_i[3:0], 8'h00};
          default:     einfo_d = info_full;
        endcase
        if (entry_done) begin
          idx_d = '0;
          if (count_q != COUNT_MAX) count_d = count_q + 8'd1;
          if (!afound_q && etype_q == audio_type_i) begin
            afound_d = 1'b1;
            apid_d   = epid_q;
          end
          if (!vfound_q && etype_q == video_type_i) begin
            vfound_d = 1'b1;
            vpid_d   = epid_q;
          end
          if (info_full != '0) skip_d = info_full;
          res_valid_o = 1'b1;
          res_kind    = KIND_ENTRY;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  // result record from the updated state
  always_comb begin
    res_o.kind         = res_kind;
    res_o.tbl_id       = tid_d;
    res_o.prog_num     = prog_d;
    res_o.strm_type    = (res_kind == KIND_SUMMARY) ? '0 : etype_d;
    res_o.es_pid       = (res_kind == KIND_SUMMARY) ? '0 : epid_d;
    res_o.es_desc_len  = (res_kind == KIND_SUMMARY) ? '0 : einfo_d;
    res_o.stream_count = count_d;
    res_o.audio_pid    = apid_d;
    res_o.audio_found  = afound_d;
    res_o.video_pid    = vpid_d;
    res_o.video_found  = vfound_d;
    res_o.malformed    = err_d;
  end

  assign phase_o = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      len_q    <= '0;
      skip_q   <= '0;
      idx_q    <= '0;
      etype_q  <= '0;
      epid_q   <= '0;
      einfo_q  <= '0;
      tid_q    <= '0;
      prog_q   <= '0;
      count_q  <= '0;
      afound_q <= 1'b0;
      apid_q   <= '0;
      vfound_q <= 1'b0;
      vpid_q   <= '0;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      idx_q    <= idx_d;
      etype_q  <= etype_d;
      epid_q   <= epid_d;
      einfo_q  <= einfo_d;
      tid_q    <= tid_d;
      prog_q   <= prog_d;
      count_q  <= count_d;
      afound_q <= afound_d;
      apid_q   <= apid_d;
      vfound_q <= vfound_d;
      vpid_q   <= vpid_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== design/pmt_out_skid.sv =====
// ----------------------------------------------------------------------------
// pmt_out_skid: result register with skid stage
// Holds a waiting result and takes one more while the sink stalls.
// ----------------------------------------------------------------------------
module pmt_out_skid
  import pmt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_ready_i,
  output res_t data_o
);

  logic main_valid_q, main_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t main_q, main_d;
  res_t skid_q, skid_d;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || pop_ready_i) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ===== design/pmt_section_parser.sv =====
// ----------------------------------------------------------------------------
// pmt_section_parser: byte-serial MPEG-2 program map section parser
// Emits one record per elementary stream entry and a summary per section.
// ----------------------------------------------------------------------------
// output: each result is registered, via the skid stage if the sink stalls
// throughput: one section byte per cycle while in_i ready, set by the single-pass decode
// the result register plus a one-deep skid stage keep in_i ready while a
// result waits; in_i ready drops only when both hold a result
// reset: parser goes idle, waiting for a section start; stream type
// registers return to audio 3 and video 2; no clearing pass is needed
module pmt_section_parser
  import pmt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  pmt_in_if.sink             in_i,
  pmt_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic       cfg_sel;
  logic [7:0] audio_q;
  logic [7:0] video_q;
  logic       cfg_wr;
  logic       in_fire;
  logic       res_valid;
  res_t       res;
  res_t       out_res;
  phase_e     phase;

  // ---------------------------------------------------------------------------
  // configuration registers, word index taken from paddr bit 2
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_q <= AUDIO_RESET;
      video_q <= VIDEO_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_AUDIO: audio_q <= pwdata[7:0];
        REG_VIDEO: video_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_AUDIO: prdata = {24'h0, audio_q};
      REG_VIDEO: prdata = {24'h0, video_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // byte decode: all state updates and the result happen on the transfer edge
  // ---------------------------------------------------------------------------
  assign in_fire = in_i.valid && in_i.ready;

  pmt_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_fire_i       (in_fire),
    .data_byte_i     (in_i.data_byte),
    .section_start_i (in_i.section_start),
    .audio_type_i    (audio_q),
    .video_type_i    (video_q),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .phase_o         (phase)
  );

  // ---------------------------------------------------------------------------
  // result register and skid stage towards the sink
  // ---------------------------------------------------------------------------
  pmt_out_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (in_i.ready),
    .valid_o     (out_o.valid),
    .pop_ready_i (out_o.ready),
    .data_o      (out_res)
  );

  assign out_o.kind         = out_res.kind;
  assign out_o.tbl_id       = out_res.tbl_id;
  assign out_o.prog_num     = out_res.prog_num;
  assign out_o.strm_type    = out_res.strm_type;
  assign out_o.es_pid       = out_res.es_pid;
  assign out_o.es_desc_len  = out_res.es_desc_len;
  assign out_o.stream_count = out_res.stream_count;
  assign out_o.audio_pid    = out_res.audio_pid;
  assign out_o.audio_found  = out_res.audio_found;
  assign out_o.video_pid    = out_res.video_pid;
  assign out_o.video_found  = out_res.video_found;
  assign out_o.malformed    = out_res.malformed;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a result only ever comes from an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_fire)
    else $error("result without an input transfer");

  // a summary closes the section
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == KIND_SUMMARY) |=> phase == PH_IDLE)
    else $error("parser not idle after section summary");

  // an entry record always counts itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == KIND_ENTRY) |-> res.stream_count != 8'd0)
    else $error("entry record with zero stream count");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the program map section parser
// Sends PMT sections byte by byte and compares every entry record and section
// summary field by field with a predictor kept inside the testbench. A short
// table of directed bytes comes first, then phases of random sections, each
// phase under its own pair of stream type registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import pmt_pkg::*;

  localparam int IDLE_PCT     = 19;      // chance of a gap per cycle, each side
  localparam int LONG_HOLD    = 200;     // cycles of the long receiver hold-off
  localparam int DRAIN_CYCLES = 4;       // result register, skid stage, margin
  localparam int PHASE_BYTES  = 110;     // random section bytes per phase
  localparam int NUM_PHASES   = 5;
  localparam int MAX_PRINTS   = 40;
  localparam int TIMEOUT_NS   = 2000000;

  typedef enum int {
    SEC_WELL,      // length field matches the content
    SEC_OVERRUN,   // length field random, descriptor lengths partly random
    SEC_CUT        // abandoned part way by the next section start
  } sec_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start;
    logic       typed;     // expected result written into the row
    res_t       res;
  } stim_row_t;

  localparam res_t NO_RES = '0;
  // short section: summary with the header values and malformed set
  localparam res_t SHORT_SUMMARY = '{
    kind: KIND_SUMMARY, tbl_id: 8'hFF, prog_num: 16'hFFFF,
    malformed: 1'b1, default: '0
  };

  localparam int DIR_ROWS = 17;
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'h5A, 1'b0, 1'b0, NO_RES},         // ignored while idle
    '{8'h00, 1'b1, 1'b0, NO_RES},         // table id 0, abandoned below
    '{8'hB0, 1'b0, 1'b0, NO_RES},
    '{8'h40, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES},         // restart in the middle of a header
    '{8'hF0, 1'b0, 1'b0, NO_RES},         // reserved bits set, length high 0
    '{8'h0C, 1'b0, 1'b0, NO_RES},         // section length 12, too short
    '{8'hFF, 1'b0, 1'b0, NO_RES},         // program number 0xffff
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},         // program info length high
    '{8'hFF, 1'b0, 1'b1, SHORT_SUMMARY},  // last header byte ends the section
    '{8'h47, 1'b0, 1'b0, NO_RES}          // idle again, ignored
  };

  logic clk;
  logic rst_n;

  pmt_in_if  in_if ();
  pmt_out_if out_if ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pmt_section_parser dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // predictor state: stream type registers and the parser's own state
  // --------------------------------------------------------------------------
  logic [7:0]       cfg_audio;
  logic [7:0]       cfg_video;
  phase_e           parse_ph;
  logic [POS_W-1:0] pos;
  logic [LEN_W-1:0] sec_len;
  logic [LEN_W-1:0] skip_left;
  logic [IDX_W-1:0] ent_idx;
  logic [7:0]       ent_type;
  logic [PID_W-1:0] ent_pid;
  logic [LEN_W-1:0] ent_len;
  logic [7:0]       hdr_tid;
  logic [15:0]      hdr_prog;
  logic [7:0]       n_streams;
  logic             aud_hit;
  logic [PID_W-1:0] aud_pid;
  logic             vid_hit;
  logic [PID_W-1:0] vid_pid;
  logic             bad_section;

  res_t expected_q [$];   // records and summaries still to come out
  int   errors;
  bit   calm;             // no gaps on either side while set
  int   hold_reqs;        // long hold-offs asked by the stimulus
  int   holds_done;       // long hold-offs carried out by the receiver

  // clear the per-section state, keeping the table id of the start byte
  function automatic void open_section(input logic [7:0] tid);
    pos         = '0;
    parse_ph    = PH_HEADER;
    sec_len     = '0;
    skip_left   = '0;
    ent_idx     = '0;
    ent_type    = '0;
    ent_pid     = '0;
    ent_len     = '0;
    hdr_prog    = '0;
    n_streams   = '0;
    aud_hit     = 1'b0;
    aud_pid     = '0;
    vid_hit     = 1'b0;
    vid_pid     = '0;
    bad_section = 1'b0;
    hdr_tid     = tid;
  endfunction

  // an entry record carries the running summary values too
  function automatic res_t make_record(input logic k);
    res_t r;
    r          = '0;
    r.kind     = k;
    r.tbl_id   = hdr_tid;
    r.prog_num = hdr_prog;
    if (k == KIND_ENTRY) begin
      r.strm_type   = ent_type;
      r.es_pid      = ent_pid;
      r.es_desc_len = ent_len;
    end
    r.stream_count = n_streams;
    r.audio_pid    = aud_pid;
    r.audio_found  = aud_hit;
    r.video_pid    = vid_pid;
    r.video_found  = vid_hit;
    r.malformed    = bad_section;
    return r;
  endfunction

  // advance the predictor by one accepted byte
  function automatic void parse_byte(input logic [7:0] b, input logic s,
                                     output bit emit, output res_t r);
    int crc_at;
    int last_at;
    emit = 1'b0;
    r    = '0;
    if (s) begin
      // a start byte always opens a new section, abandoning any other
      open_section(b);
      return;
    end
    if (parse_ph == PH_IDLE) return;
    pos = pos + POS_W'(1);

    if (parse_ph == PH_HEADER) begin
      case (pos)
        POS_LEN_HI:  sec_len = {b[3:0], 8'h00};
        POS_LEN_LO:  sec_len[7:0] = b;
        POS_PROG_HI: hdr_prog = {b, 8'h00};
        POS_PROG_LO: hdr_prog[7:0] = b;
        POS_INFO_HI: skip_left = {b[3:0], 8'h00};
        POS_INFO_LO: begin
          skip_left[7:0] = b;
          if (sec_len < MIN_SECTION_LEN) begin
            // no room for header and crc: summary straight away
            bad_section = 1'b1;
            parse_ph    = PH_IDLE;
            emit        = 1'b1;
            r           = make_record(KIND_SUMMARY);
            return;
          end
          parse_ph = (skip_left != '0) ? PH_SKIP : PH_ENTRY;
          ent_idx  = '0;
        end
        default: ;
      endcase
      return;
    end

    crc_at  = int'(sec_len) - 1;
    last_at = int'(sec_len) + 2;

    if (int'(pos) >= crc_at) begin
      // crc bytes: anything unfinished here marks the section malformed
      if (parse_ph != PH_TRAILER) begin
        if (parse_ph == PH_SKIP || (parse_ph == PH_ENTRY && ent_idx != ENT_TYPE))
          bad_section = 1'b1;
        parse_ph = PH_TRAILER;
      end
      if (int'(pos) >= last_at) begin
        parse_ph = PH_IDLE;
        emit     = 1'b1;
        r        = make_record(KIND_SUMMARY);
      end
      return;
    end

    if (parse_ph == PH_SKIP) begin
      skip_left = skip_left - LEN_W'(1);
      if (skip_left == '0) begin
        parse_ph = PH_ENTRY;
        ent_idx  = '0;
      end
      return;
    end

    if (parse_ph == PH_ENTRY) begin
      case (ent_idx)
        ENT_TYPE:    ent_type = b;
        ENT_PID_HI:  ent_pid = {b[4:0], 8'h00};
        ENT_PID_LO:  ent_pid[7:0] = b;
        ENT_INFO_HI: ent_len = {b[3:0], 8'h00};
        default:     ent_len[7:0] = b;
      endcase
      if (ent_idx != ENT_LAST) begin
        ent_idx = ent_idx + IDX_W'(1);
        return;
      end
      ent_idx = '0;
      if (n_streams != COUNT_MAX) n_streams = n_streams + 8'd1;
      // first match wins for each of audio and video
      if (!aud_hit && ent_type == cfg_audio) begin
        aud_hit = 1'b1;
        aud_pid = ent_pid;
      end
      if (!vid_hit && ent_type == cfg_video) begin
        vid_hit = 1'b1;
        vid_pid = ent_pid;
      end
      if (ent_len != '0) begin
        skip_left = ent_len;
        parse_ph  = PH_SKIP;
      end
      emit = 1'b1;
      r    = make_record(KIND_ENTRY);
    end
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp);
    if (got !== exp)
      note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp));
  endtask

  task automatic compare_result(input res_t got, input res_t exp);
    check_field("kind", 16'(got.kind), 16'(exp.kind));
    check_field("tbl_id", 16'(got.tbl_id), 16'(exp.tbl_id));
    check_field("prog_num", got.prog_num, exp.prog_num);
    check_field("strm_type", 16'(got.strm_type), 16'(exp.strm_type));
    check_field("es_pid", 16'(got.es_pid), 16'(exp.es_pid));
    check_field("es_desc_len", 16'(got.es_desc_len), 16'(exp.es_desc_len));
    check_field("stream_count", 16'(got.stream_count), 16'(exp.stream_count));
    check_field("audio_pid", 16'(got.audio_pid), 16'(exp.audio_pid));
    check_field("audio_found", 16'(got.audio_found), 16'(exp.audio_found));
    check_field("video_pid", 16'(got.video_pid), 16'(exp.video_pid));
    check_field("video_found", 16'(got.video_found), 16'(exp.video_found));
    check_field("malformed", 16'(got.malformed), 16'(exp.malformed));
  endtask

  // every result transfer is matched against the oldest expectation
  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen.kind         = out_if.kind;
      seen.tbl_id       = out_if.tbl_id;
      seen.prog_num     = out_if.prog_num;
      seen.strm_type    = out_if.strm_type;
      seen.es_pid       = out_if.es_pid;
      seen.es_desc_len  = out_if.es_desc_len;
      seen.stream_count = out_if.stream_count;
      seen.audio_pid    = out_if.audio_pid;
      seen.audio_found  = out_if.audio_found;
      seen.video_pid    = out_if.video_pid;
      seen.video_found  = out_if.video_found;
      seen.malformed    = out_if.malformed;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected, kind %0d", seen.kind));
      end else begin
        want = expected_q.pop_front();
        compare_result(seen, want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random gaps, or a long hold-off when the stimulus asks
  // --------------------------------------------------------------------------
  always begin
    @(negedge clk);
    if (hold_reqs != holds_done) begin
      holds_done++;
      out_if.ready <= 1'b0;
      repeat (LONG_HOLD - 1) @(negedge clk);
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // one register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_AUDIO) cfg_audio = val;
    else cfg_video = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one byte, with random gaps, until the transfer; called at a falling
  // edge and returns at one
  task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                           input res_t typed_res);
    bit   emit;
    res_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.section_start <= s;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    parse_byte(b, s, emit, r);
    if (typed) expected_q.push_back(typed_res);
    else if (emit) expected_q.push_back(r);
    @(negedge clk);
  endtask

  // stop offering and wait until every result is in and the block has settled
  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // build one section and send it; returns the number of bytes sent
  task automatic send_section(input int n_ent, input int pil, input int esl_max,
                              input sec_mode_e mode, output int n_sent);
    logic [7:0]       body [$];
    logic [7:0]       hdr [$];
    logic [7:0]       b;
    logic [7:0]       st;
    logic [LEN_W-1:0] len_fld;
    logic [LEN_W-1:0] pil_fld;
    logic [LEN_W-1:0] esl_fld;
    logic [PID_W-1:0] pid;
    logic [15:0]      prog;
    int               placed;
    int               real_len;
    int               total;

    pil_fld = LEN_W'(pil);
    if (mode == SEC_OVERRUN && $urandom_range(3) == 0) pil_fld = LEN_W'($urandom);
    repeat (pil) body.push_back(8'($urandom));

    for (int e = 0; e < n_ent; e++) begin
      case ($urandom_range(3))
        0:       st = cfg_audio;
        1:       st = cfg_video;
        default: st = 8'($urandom);
      endcase
      pid     = PID_W'($urandom);
      esl_fld = (esl_max != 0 && $urandom_range(2) == 0) ?
                LEN_W'($urandom_range(1, esl_max)) : '0;
      placed  = int'(esl_fld);
      // huge descriptor length with only a few bytes behind it
      if (mode == SEC_OVERRUN && $urandom_range(3) == 0) begin
        esl_fld = LEN_W'($urandom);
        placed  = int'(esl_fld[2:0]);
      end
      body.push_back(st);
      body.push_back({3'($urandom), pid[12:8]});
      body.push_back(pid[7:0]);
      body.push_back({4'($urandom), esl_fld[11:8]});
      body.push_back(esl_fld[7:0]);
      repeat (placed) body.push_back(8'($urandom));
    end
    repeat (4) body.push_back(8'($urandom));   // crc

    real_len = int'(HEADER_BYTES) - 3 + body.size();
    if (mode == SEC_OVERRUN) begin
      real_len = $urandom_range(real_len + 6);
      if (real_len > 4095) real_len = 4095;
    end
    len_fld = LEN_W'(real_len);
    prog    = 16'($urandom);

    hdr.push_back(8'($urandom));                  // table id
    hdr.push_back({4'($urandom), len_fld[11:8]});
    hdr.push_back(len_fld[7:0]);
    hdr.push_back(prog[15:8]);
    hdr.push_back(prog[7:0]);
    repeat (5) hdr.push_back(8'($urandom));
    hdr.push_back({4'($urandom), pil_fld[11:8]});
    hdr.push_back(pil_fld[7:0]);

    total = (len_fld < MIN_SECTION_LEN) ? int'(HEADER_BYTES) : real_len + 3;
    if (mode == SEC_CUT) total = $urandom_range(1, total - 1);

    for (int i = 0; i < total; i++) begin
      if (i < hdr.size()) b = hdr[i];
      else if (i - hdr.size() < body.size()) b = body[i - hdr.size()];
      else b = 8'($urandom);
      send_byte(b, (i == 0), 1'b0, NO_RES);
    end
    n_sent = total;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          phase_bytes;
    int          n;
    int          pick;
    logic [7:0]  same_type;

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.section_start = 1'b0;
    out_if.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    errors              = 0;
    calm                = 1'b0;
    hold_reqs           = 0;
    holds_done          = 0;

    // predictor reset: idle, table id 0, registers at reset values
    cfg_audio = AUDIO_RESET;
    cfg_video = VIDEO_RESET;
    open_section(8'h00);
    parse_ph = PH_IDLE;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed bytes
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIR_TABLE[i].data_byte, DIR_TABLE[i].start, DIR_TABLE[i].typed,
                DIR_TABLE[i].res);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // a new pair of stream types, written only with the block idle
      same_type = 8'($urandom);
      case (p)
        0: begin
          write_reg(REG_AUDIO, AUDIO_RESET);
          write_reg(REG_VIDEO, VIDEO_RESET);
        end
        1: begin
          write_reg(REG_AUDIO, 8'h00);
          write_reg(REG_VIDEO, 8'hFF);
        end
        2: begin
          write_reg(REG_AUDIO, 8'hFF);
          write_reg(REG_VIDEO, 8'h00);
        end
        3: begin
          write_reg(REG_AUDIO, 8'($urandom));
          write_reg(REG_VIDEO, 8'($urandom));
        end
        default: begin
          // one type for both: a single entry can be audio and video
          write_reg(REG_AUDIO, same_type);
          write_reg(REG_VIDEO, same_type);
        end
      endcase
      @(negedge clk);

      phase_bytes = 0;
      calm        = (p == 3);

      if (p == 1) begin
        // hold the results back while a dense section keeps coming, so the
        // result stages fill and the byte input stalls
        hold_reqs++;
        send_section(24, 0, 0, SEC_WELL, n);
        phase_bytes += n;
      end

      while (phase_bytes < PHASE_BYTES) begin
        if (p == 3 && phase_bytes > PHASE_BYTES / 2) calm = 1'b0;
        pick = $urandom_range(99);
        if (pick < 65)
          send_section($urandom_range(6), ($urandom_range(3) == 0) ?
                       $urandom_range(1, 5) : 0, 4, SEC_WELL, n);
        else if (pick < 80)
          send_section($urandom_range(4), $urandom_range(3), 4, SEC_OVERRUN, n);
        else if (pick < 92)
          send_section($urandom_range(1, 4), $urandom_range(2), 3, SEC_CUT, n);
        else begin
          // stray bytes without a start marker, mostly ignored
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
          n = 0;
        end
        phase_bytes += n;

        // now and then let every result out before going on
        if ($urandom_range(7) == 0) begin
          in_if.valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      calm = 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // hard limit on the run
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pmt_pkg.sv
design/pmt_in_if.sv
design/pmt_out_if.sv
design/pmt_core.sv
design/pmt_out_skid.sv
design/pmt_section_parser.sv
dv/tb_top.sv
